### design/utf8_validating_decoder_macros.svh
// Assertion helpers for the decoder; compiled out when SYNTH is defined.
`ifndef UTF8_VALIDATING_DECODER_MACROS_SVH
`define UTF8_VALIDATING_DECODER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define U8D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked out of reset.
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define U8D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/u8d_pkg.sv
package u8d_pkg;

	localparam int unsigned MAX_RES  = 4;
	localparam int unsigned PEND_MAX = 3;

	localparam logic [20:0] REPL_CHAR = 21'h00FFFD;

	// Outcome of examining the sequence that starts at one byte position
	typedef enum logic [1:0] {
		SEQ_DONE,
		SEQ_BAD,
		SEQ_WAIT
	} seq_kind_t;

	typedef struct packed {
		seq_kind_t   kind;
		logic [2:0]  len;
		logic [20:0] cp;
	} seq_cls_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        run_last;
		logic        text_end;
	} res_t;

	// All results caused by one input item
	typedef struct packed {
		logic [2:0]           count;
		res_t [MAX_RES-1:0]   res;
	} dec_out_t;

endpackage

### design/u8d_byte_if.sv
interface u8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       text_last;

	modport source (output valid, output in_byte, output text_last, input ready);
	modport sink   (input valid, input in_byte, input text_last, output ready);
endinterface

### design/u8d_cp_if.sv
interface u8d_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        run_last;
	logic        text_end;

	modport source (output valid, output code_point, output run_last, output text_end,
		input ready);
	modport sink   (input valid, input code_point, input run_last, input text_end,
		output ready);
endinterface

### design/u8d_decode.sv
module u8d_decode (
	input  logic [2:0][7:0]  pend,
	input  logic [1:0]       pend_cnt,
	input  logic [7:0]       in_byte,
	input  logic             text_last,
	output u8d_pkg::dec_out_t dec,
	output logic [2:0][7:0]  pend_nxt,
	output logic [1:0]       pend_cnt_nxt
);
	import u8d_pkg::*;

	logic [3:0][7:0] bytes;
	logic [2:0]      n;
	seq_cls_t        cls [4];

	logic [7:0]  b0, bb, lo, hi;
	logic [2:0]  need, avail;
	logic        ok;
	logic [7:0]  c1, c2, c3;

	logic [2:0]  pos;
	logic [2:0]  k;
	logic        stop;
	seq_cls_t    cur;
	logic [31:0] shifted;

	// Working window: held bytes followed by the new one
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < {1'b0, pend_cnt}) begin
				bytes[i] = (i < 3) ? pend[i[1:0]] : 8'h00;
			end else if (3'(i) == {1'b0, pend_cnt}) begin
				bytes[i] = in_byte;
			end else begin
				bytes[i] = 8'h00;
			end
		end
		n = {1'b0, pend_cnt} + 3'd1;
	end

	// Classify the sequence starting at each position, all in parallel
	always_comb begin
		for (int p = 0; p < 4; p++) begin
			b0    = bytes[p];
			avail = n - 3'(p);
			need  = 3'd0;
			lo    = 8'h80;
			hi    = 8'hBF;
			if (b0 >= 8'hC2 && b0 <= 8'hDF) begin
				need = 3'd2;
			end else if (b0 >= 8'hE0 && b0 <= 8'hEF) begin
				need = 3'd3;
				if (b0 == 8'hE0) lo = 8'hA0;
				if (b0 == 8'hED) hi = 8'h9F;
			end else if (b0 >= 8'hF0 && b0 <= 8'hF4) begin
				need = 3'd4;
				if (b0 == 8'hF0) lo = 8'h90;
				if (b0 == 8'hF4) hi = 8'h8F;
			end
			ok = 1'b1;
			for (int i = 1; i < 4; i++) begin
				bb = (p + i < 4) ? bytes[(p + i) % 4] : 8'h00;
				if (p + i < 4 && 3'(i) < need && 3'(i) < avail) begin
					if (i == 1) begin
						ok = ok & (bb >= lo) & (bb <= hi);
					end else begin
						ok = ok & (bb[7:6] == 2'b10);
					end
				end
			end
			c1 = (p + 1 < 4) ? bytes[(p + 1) % 4] : 8'h00;
			c2 = (p + 2 < 4) ? bytes[(p + 2) % 4] : 8'h00;
			c3 = (p + 3 < 4) ? bytes[(p + 3) % 4] : 8'h00;

			cls[p].len = need;
			cls[p].cp  = REPL_CHAR;
			if (b0[7] == 1'b0) begin
				cls[p].kind = SEQ_DONE;
				cls[p].len  = 3'd1;
				cls[p].cp   = {14'd0, b0[6:0]};
			end else if (need == 3'd0 || !ok) begin
				cls[p].kind = SEQ_BAD;
				cls[p].len  = 3'd1;
			end else if (avail < need) begin
				cls[p].kind = SEQ_WAIT;
			end else begin
				cls[p].kind = SEQ_DONE;
				case (need)
					3'd2:    cls[p].cp = {10'd0, b0[4:0], c1[5:0]};
					3'd3:    cls[p].cp = {5'd0, b0[3:0], c1[5:0], c2[5:0]};
					default: cls[p].cp = {b0[2:0], c1[5:0], c2[5:0], c3[5:0]};
				endcase
			end
		end
	end

	// Walk the window from the front, one sequence per step
	always_comb begin
		pos  = 3'd0;
		k    = 3'd0;
		stop = 1'b0;
		cur  = cls[0];
		dec  = '0;
		for (int s = 0; s < 4; s++) begin
			if (!stop && pos < n) begin
				cur = cls[pos[1:0]];
				unique case (cur.kind)
					SEQ_DONE: begin
						dec.res[k[1:0]].code_point = cur.cp;
						k   = k + 3'd1;
						pos = pos + cur.len;
					end
					SEQ_BAD: begin
						dec.res[k[1:0]].code_point = REPL_CHAR;
						k   = k + 3'd1;
						pos = pos + 3'd1;
					end
					SEQ_WAIT: begin
						if (text_last) begin
							dec.res[k[1:0]].code_point = REPL_CHAR;
							k   = k + 3'd1;
							pos = pos + 3'd1;
						end else begin
							stop = 1'b1;
						end
					end
					default: stop = 1'b1;
				endcase
			end
		end
		for (int j = 0; j < 4; j++) begin
			dec.res[j].run_last = (k == 3'(j + 1));
			dec.res[j].text_end = (k == 3'(j + 1)) & text_last;
		end
		dec.count = k;

		// Keep the unfinished tail
		shifted      = 32'(bytes) >> {pos, 3'b000};
		pend_nxt     = shifted[23:0];
		pend_cnt_nxt = 2'(n - pos);
	end

endmodule

### design/u8d_result_buf.sv
`include "utf8_validating_decoder_macros.svh"

module u8d_result_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  u8d_pkg::dec_out_t load_data,
	output logic              load_ok,
	u8d_cp_if.source          points
);
	import u8d_pkg::*;

	res_t       res_q [MAX_RES];
	logic [2:0] cnt_q;
	logic [1:0] rd_q;
	logic       take;
	logic       at_tail;

	assign at_tail = ({1'b0, rd_q} + 3'd1 == cnt_q);
	assign take    = points.valid & points.ready;
	assign load_ok = (cnt_q == 3'd0) | (take & at_tail);

	assign points.valid      = (cnt_q != 3'd0);
	assign points.code_point = res_q[rd_q].code_point;
	assign points.run_last   = res_q[rd_q].run_last;
	assign points.text_end   = res_q[rd_q].text_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			rd_q  <= 2'd0;
		end else if (load) begin
			cnt_q <= load_data.count;
			rd_q  <= 2'd0;
		end else if (take) begin
			if (at_tail) begin
				cnt_q <= 3'd0;
				rd_q  <= 2'd0;
			end else begin
				rd_q <= rd_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RES; i++) res_q[i] <= load_data.res[i];
		end
	end

	`U8D_ASSERT_NOW(a_rd_in_range, clk, arst_n, cnt_q != 3'd0, {1'b0, rd_q} < cnt_q, "read index past count")
	`U8D_ASSERT_NEXT(a_load_shows, clk, arst_n, load && load_data.count != 3'd0, points.valid && rd_q == 2'd0, "loaded results not shown")
	`U8D_ASSERT_NEXT(a_advance, clk, arst_n, take && !at_tail && !load, rd_q == $past(rd_q) + 2'd1, "read index did not advance")

endmodule

### design/utf8_validating_decoder.sv
// UTF-8 validating decoder.
// text   : sink channel of raw bytes (in_byte), text_last set on the final byte of a text.
// points : source channel of code points; run_last marks the last result caused by
//          one byte, text_end the final result of a text.
// Each byte causes zero to four results. Malformed or truncated sequences give
// U+FFFD for their lead byte, after which the following bytes are examined again.
// A byte accepted from text waits in the input stage until the result buffer can
// take its results; its first result is offered in the cycle after they are loaded,
// and further results of the same byte follow one per cycle while points.ready is high.
// Throughput: one byte per cycle while each byte yields at most one result and the
// receiver takes each result; the output port moves one result per cycle, so a byte
// with several results holds the next byte in the input stage until its last is taken.
// Reset: nothing pending, input stage and result buffer empty.
// When the receiver stalls the result buffer holds its entry, the decoded byte
// waits in the input stage and text.ready falls once both are full.
`include "utf8_validating_decoder_macros.svh"

module utf8_validating_decoder (
	input  logic       clk,
	input  logic       arst_n,
	u8d_byte_if.sink   text,
	u8d_cp_if.source   points
);
	import u8d_pkg::*;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Held prefix of an incomplete sequence
	logic [2:0][7:0] pend_q;
	logic [1:0]      pend_cnt_q;

	dec_out_t        dec;
	logic [2:0][7:0] pend_nxt;
	logic [1:0]      pend_cnt_nxt;
	logic            load_ok;
	logic            advance;

	// Decode the staged byte when the result buffer can take its results
	assign advance    = valid_s1 & load_ok;
	assign text.ready = ~valid_s1 | load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.in_byte;
			last_s1 <= text.text_last;
		end
	end

	// Advance the held prefix as each byte is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= 2'd0;
		end else if (advance) begin
			pend_cnt_q <= pend_cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pend_q <= pend_nxt;
		end
	end

	u8d_decode u_decode (
		.pend         (pend_q),
		.pend_cnt     (pend_cnt_q),
		.in_byte      (byte_s1),
		.text_last    (last_s1),
		.dec          (dec),
		.pend_nxt     (pend_nxt),
		.pend_cnt_nxt (pend_cnt_nxt)
	);

	u8d_result_buf u_result_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.load_data (dec),
		.load_ok   (load_ok),
		.points    (points)
	);

	`U8D_ASSERT_NOW(a_end_is_last, clk, arst_n, points.valid && points.text_end, points.run_last, "text end off the last result")
	`U8D_ASSERT_NEXT(a_flush_on_end, clk, arst_n, advance && last_s1, pend_cnt_q == 2'd0, "bytes held past end of text")
	`U8D_ASSERT_NEXT(a_silent_grows, clk, arst_n, advance && dec.count == 3'd0, pend_cnt_q == $past(pend_cnt_q) + 2'd1, "silent byte not held")

endmodule
